FILE: rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  localparam logic FUNC_ABSORB   = 1'b0;
  localparam logic FUNC_FINALIZE = 1'b1;

  // Queue entry from front to back: either a byte to store or a finalize.
  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } cmd_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[r];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256_message_hasher.sv
`default_nettype none
// SHA-256 hasher over a byte stream of any length.
// Input channel: in_valid_i/in_stall_o with in_data_i (func, data_byte).
// func absorb appends one byte; func finalize pads the message, runs the
// last block(s) and emits eight digest words on the output channel
// (out_valid_o/out_stall_i, out_data_o), word 0 first, last_word on word 7.
// A four-entry command queue parts the input from the hashing engine, so
// bytes keep arriving while a block compresses.
// Throughput: one byte per cycle while no block runs; each 64th byte starts
// a compression (load, 64 rounds, add) on the one round unit, during which
// no bytes leave the queue. Finalize shifts in the padding bytes, writes
// the length field, compresses, then emits the eight output words.
// Reset loads the initial hash values and clears counters and queue.
// When the receiver stalls, the current digest word holds and the engine
// waits; the queue fills and then stalls the sender.
module sha256_message_hasher import sha256_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  sha256_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  sha256_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
`default_nettype wire

FILE: rtl/core/sha256_front.sv
`default_nettype none
// Input side: take words and queue them as commands for the back end.
module sha256_front import sha256_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_data_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_pop_i
);

  cmd_t          mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;
  logic           push;

  assign in_stall_o  = (cnt_q == QAW'(0) + (QAW+1)'(QDEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].fin  <= (in_data_i.func == FUNC_FINALIZE);
      mem_q[wr_q].data <= in_data_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(cmd_pop_i);
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != '0) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (QAW+1)'(QDEPTH)) |-> !push) else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: rtl/core/sha256_back.sv
`default_nettype none
// Back end: block buffer, padding sequencer, one round per cycle, digest out.
module sha256_back import sha256_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire cmd_t      cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_LEN   = 7'b0000100,
    S_INIT  = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  buf_q [64];
  logic [5:0]  cnt_q;
  logic [63:0] bitlen_q, total_q;
  logic        fin_q, second_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;

  logic [31:0] w_new, wr, t1, t2, s0, s1;
  logic [31:0] e, a;
  logic        shift_en;
  logic [7:0]  shift_byte;

  always_comb begin
    s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    wr    = w_q[0];
    e     = v_q[4];
    a     = v_q[0];
    t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(rnd_q) + wr;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Shift one byte into the tail of the block buffer: a message byte, the
  // 0x80 marker on finalize, or a padding zero.
  always_comb begin
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    if (state_q == S_IDLE && cmd_valid_i) begin
      shift_en   = 1'b1;
      shift_byte = cmd_i.fin ? PAD_BYTE : cmd_i.data;
    end else if (state_q == S_PAD && (cnt_q != 6'd63 || second_q)) begin
      shift_en = 1'b1;
    end
  end

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = '{digest_word: h_q[oidx_q], word_index: oidx_q,
                         last_word: (oidx_q == 3'd7)};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_valid_i) begin
        if (cmd_i.fin) state_d = S_PAD;
        else if (cnt_q == 6'd63) state_d = S_INIT;
      end
      S_PAD:  state_d = (cnt_q == 6'd63) ?
                        ((!second_q && total_q[8:3] >= LEN_POS) ? S_INIT : S_LEN) : S_PAD;
      S_LEN:  state_d = S_INIT;
      S_INIT: state_d = S_ROUND;
      S_ROUND: if (rnd_q == 6'd63) state_d = S_ADD;
      S_ADD:  state_d = !fin_q ? S_IDLE : (second_q ? S_PAD : S_OUT);
      S_OUT:  if (!out_stall_i && oidx_q == 3'd7) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Padding: PAD shifts in one zero per cycle until 64 bytes have entered;
  // second_q marks that the length still goes in a following extra block,
  // which is all zeros up to the length field.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 63; i++) buf_q[i] <= buf_q[i+1];
      buf_q[63] <= shift_byte;
    end
    if (state_q == S_LEN)
      for (int i = 0; i < 8; i++) buf_q[56 + i] <= total_q[63 - 8*i -: 8];
    if (state_q == S_INIT)
      for (int i = 0; i < 16; i++)
        w_q[i] <= {buf_q[4*i], buf_q[4*i+1], buf_q[4*i+2], buf_q[4*i+3]};
    else if (state_q == S_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
    if (state_q == S_INIT) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    else if (state_q == S_ROUND) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      bitlen_q <= '0;
      total_q  <= '0;
      fin_q    <= 1'b0;
      second_q <= 1'b0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          if (cmd_i.fin) begin
            fin_q    <= 1'b1;
            second_q <= 1'b0;
            total_q  <= bitlen_q + {55'd0, cnt_q, 3'd0};
          end else begin
            fin_q <= 1'b0;
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd63) bitlen_q <= bitlen_q + 64'd512;
          end
        end
        S_PAD: begin
          if (cnt_q == 6'd63) begin
            if (!second_q && state_d == S_INIT) second_q <= 1'b1;
            else second_q <= 1'b0;
          end else cnt_q <= cnt_q + 6'd1;
        end
        S_INIT: rnd_q <= '0;
        S_ROUND: rnd_q <= rnd_q + 6'd1;
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          cnt_q  <= '0;
          oidx_q <= '0;
        end
        S_OUT: if (!out_stall_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
            bitlen_q <= '0;
            fin_q    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == S_IDLE) else $error("pop outside idle");
  a_out_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fin_q) else $error("digest without finalize");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> state_q == S_ADD)
    else $error("round count slip");

endmodule
`default_nettype wire
